>>> rtl/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types, widths and codes for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

   // Default fixed-point fraction width (Q16.16)
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int LANES    = 4;
   localparam int LANE_W   = 32;
   localparam int PROD_W   = 2 * LANE_W;
   localparam int PAIR_W   = PROD_W + 1;
   localparam int SUM_W    = PROD_W + 2;
   localparam int ROW_W    = 2;

   // Result queue depth and its index / count widths
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Transaction kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_XFORM = 1'b1;

   typedef struct packed {
      logic                     kind;
      logic [ROW_W-1:0]         row_sel;
      logic signed [LANE_W-1:0] lane0;
      logic signed [LANE_W-1:0] lane1;
      logic signed [LANE_W-1:0] lane2;
      logic signed [LANE_W-1:0] lane3;
   } hvt_req_type;

   typedef struct packed {
      logic signed [LANE_W-1:0] out_x;
      logic signed [LANE_W-1:0] out_y;
      logic signed [LANE_W-1:0] out_z;
      logic signed [LANE_W-1:0] out_w;
   } hvt_rsp_type;

endpackage

>>> rtl/hvt_lane.sv
// ----------------------------------------------------------------------------
// hvt_lane
// One output column: four products, a pair-add stage, then the final add,
// arithmetic shift by the fraction width and saturation to 32 bits.
// ----------------------------------------------------------------------------
module hvt_lane #(
   parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic signed [hvt_pkg::LANE_W-1:0] vec [hvt_pkg::LANES],
   input  logic signed [hvt_pkg::LANE_W-1:0] col [hvt_pkg::LANES],
   output logic signed [hvt_pkg::LANE_W-1:0] result
);
   import hvt_pkg::*;

   logic signed [PROD_W-1:0] prod_in [LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [PAIR_W-1:0] pair_in [LANES/2];
   logic signed [PAIR_W-1:0] pair_ff [LANES/2];
   logic signed [SUM_W-1:0]  total;
   logic signed [SUM_W-1:0]  shifted;
   logic                     fits;

   // Stage 1: one 32x32 signed product per row
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         prod_in[i] = PROD_W'(vec[i]) * PROD_W'(col[i]);
      end
   end

   // Stage 2: add products in pairs
   always_comb begin
      for (int j = 0; j < LANES/2; j++) begin
         pair_in[j] = PAIR_W'(prod_ff[2*j]) + PAIR_W'(prod_ff[2*j+1]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pair_ff <= pair_in;
   end

   // Final sum is exact; the arithmetic shift floors toward minus infinity
   always_comb begin
      total   = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
      shifted = total >>> FRAC_BITS;
      fits    = (&shifted[SUM_W-1:LANE_W-1]) || !(|shifted[SUM_W-1:LANE_W-1]);
      if (fits) begin
         result = shifted[LANE_W-1:0];
      end else if (shifted[SUM_W-1]) begin
         result = {1'b1, {(LANE_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(LANE_W-1){1'b1}}};
      end
   end

endmodule

>>> rtl/hvt_merge.sv
// ----------------------------------------------------------------------------
// hvt_merge
// Merge the four lane results into one response and queue it for the
// receiver.
// ----------------------------------------------------------------------------
module hvt_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic signed [hvt_pkg::LANE_W-1:0] lane_res [hvt_pkg::LANES],
   input  logic                              pop,
   output logic                              rsp_valid,
   output hvt_pkg::hvt_rsp_type              rsp_data
);
   import hvt_pkg::*;

   hvt_rsp_type        merged;
   hvt_rsp_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      merged.out_x = lane_res[0];
      merged.out_y = lane_res[1];
      merged.out_z = lane_res[2];
      merged.out_w = lane_res[3];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= merged;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   // Credit check upstream must keep the queue from overflowing
   assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (32'(count_ff) == QUEUE_DEPTH)))
      else $error("hvt_merge: push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("hvt_merge: pop from empty queue");

endmodule

>>> rtl/homogeneous_vertex_transform_top.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_top
// Signed fixed-point row vector times 4x4 matrix, one per clock while ready.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries two kinds of transaction. A load (kind = 0)
//   writes lane0..lane3 into matrix row row_sel and produces no response.
//   A transform (kind = 1) multiplies vector (lane0..lane3) by the matrix
//   and produces one rsp_ transaction out_x..out_w, each the exact sum of
//   four products, shifted right by FRAC_BITS (floor) and saturated to
//   signed 32 bits.
//   A transform's result passes through the product stage, the pair-add
//   stage and then the response queue before rsp_valid goes high.
//   A load takes effect for a transform accepted on the very next edge.
//   Throughput: one transaction per cycle of either kind while req_ready
//   is high, set by four column lanes of four multipliers in parallel.
//   Stall: responses wait in a four-entry queue; req_ready is decoded from
//   a registered outstanding count and drops only while four transforms are
//   outstanding, so a stalled receiver never loses or repeats a response.
//   Reset: synchronous, active high; clears the matrix to zero and empties
//   the pipeline and queue.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_top #(
   parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hvt_pkg::hvt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hvt_pkg::hvt_rsp_type rsp_data
);
   import hvt_pkg::*;

   // Matrix, row-major; cleared at reset
   logic signed [LANE_W-1:0] matrix_ff [LANES][LANES];

   logic signed [LANE_W-1:0] vec [LANES];
   logic signed [LANE_W-1:0] col [LANES][LANES];
   logic signed [LANE_W-1:0] lane_res [LANES];

   logic              req_fire;
   logic              load_fire;
   logic              xform_fire;
   logic              rsp_fire;
   logic              s1_valid_ff;
   logic              s2_valid_ff;
   logic [QCNT_W-1:0] used_ff, used_in;

   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_data.kind == KIND_LOAD);
   assign xform_fire = req_fire && (req_data.kind == KIND_XFORM);
   assign rsp_fire   = rsp_valid && rsp_ready;

   // Hold new transactions once every queue slot is spoken for
   assign req_ready = (32'(used_ff) < QUEUE_DEPTH);

   always_comb begin
      used_in = used_ff;
      if (xform_fire && !rsp_fire) begin
         used_in = used_ff + 1'b1;
      end else if (rsp_fire && !xform_fire) begin
         used_in = used_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         used_ff     <= used_in;
         s1_valid_ff <= xform_fire;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Write one whole row on a load
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < LANES; r++) begin
            for (int c = 0; c < LANES; c++) begin
               matrix_ff[r][c] <= '0;
            end
         end
      end else if (load_fire) begin
         matrix_ff[req_data.row_sel][0] <= req_data.lane0;
         matrix_ff[req_data.row_sel][1] <= req_data.lane1;
         matrix_ff[req_data.row_sel][2] <= req_data.lane2;
         matrix_ff[req_data.row_sel][3] <= req_data.lane3;
      end
   end

   // Broadcast the vector; lane c sees column c of the matrix
   always_comb begin
      vec[0] = req_data.lane0;
      vec[1] = req_data.lane1;
      vec[2] = req_data.lane2;
      vec[3] = req_data.lane3;
      for (int c = 0; c < LANES; c++) begin
         for (int r = 0; r < LANES; r++) begin
            col[c][r] = matrix_ff[r][c];
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      hvt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .vec    (vec),
         .col    (col[g]),
         .result (lane_res[g])
      );
   end

   // Merge lanes and queue the response
   hvt_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .lane_res  (lane_res),
      .pop       (rsp_fire),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= QUEUE_DEPTH)
      else $error("top: outstanding count above queue depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> used_ff != '0)
      else $error("top: response present with nothing outstanding");

   assert property (@(posedge clock) disable iff (reset)
      load_fire |=> !s1_valid_ff)
      else $error("top: load transaction entered the product stage");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> s2_valid_ff)
      else $error("top: transform lost between pipeline stages");

endmodule
